// ===== src/jbt_pkg.sv =====
// Shared types, codes and helper functions for the JSON byte tokenizer.
// No dependencies; every other file imports this package.
package jbt_pkg;

  // Input transaction: one byte of JSON text
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_t;

  // Result transaction: one token or one text byte
  typedef struct packed {
    logic [3:0] token_kind;
    logic       is_text;
    logic [7:0] text_out;
    logic       last_of_item;
  } out_t;

  // Token kinds
  localparam logic [3:0] KIND_LBRACE   = 4'd0;
  localparam logic [3:0] KIND_RBRACE   = 4'd1;
  localparam logic [3:0] KIND_LBRACKET = 4'd2;
  localparam logic [3:0] KIND_RBRACKET = 4'd3;
  localparam logic [3:0] KIND_COLON    = 4'd4;
  localparam logic [3:0] KIND_COMMA    = 4'd5;
  localparam logic [3:0] KIND_TRUE     = 4'd6;
  localparam logic [3:0] KIND_STRING   = 4'd9;
  localparam logic [3:0] KIND_INT      = 4'd10;
  localparam logic [3:0] KIND_FLOAT    = 4'd11;
  localparam logic [3:0] KIND_ERROR    = 4'd12;

  // Characters of interest
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_T        = 8'h74;
  localparam logic [7:0] CH_F        = 8'h66;
  localparam logic [7:0] CH_N        = 8'h6E;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_DOT      = 8'h2E;

  // Keyword selectors
  localparam logic [1:0] KW_TRUE  = 2'd0;
  localparam logic [1:0] KW_FALSE = 2'd1;
  localparam logic [1:0] KW_NULL  = 2'd2;

  // Scanner mode, one-hot
  typedef enum logic [3:0] {
    MODE_IDLE    = 4'b0001,
    MODE_KEYWORD = 4'b0010,
    MODE_STRING  = 4'b0100,
    MODE_NUMBER  = 4'b1000
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic [1:0] kw_which;
    logic [2:0] kw_pos;
    logic       seen_dot;
    logic       seen_digit;
  } scan_t;

  localparam scan_t SCAN_IDLE = '{mode: MODE_IDLE, kw_which: 2'd0, kw_pos: 3'd0,
                                  seen_dot: 1'b0, seen_digit: 1'b0};

  // Results of one input transaction, handed from lexer to output queue
  typedef struct packed {
    logic [1:0] n;
    out_t       r0;
    out_t       r1;
  } push_t;

  // Result of handling a byte from the idle mode
  typedef struct packed {
    logic [1:0] n;
    out_t       r0;
    out_t       r1;
    scan_t      st;
  } idle_t;

  function automatic out_t mk_tok(input logic [3:0] kind);
    out_t r;
    r = '0;
    r.token_kind = kind;
    return r;
  endfunction

  function automatic out_t mk_text(input logic [3:0] kind, input logic [7:0] b);
    out_t r;
    r = '0;
    r.token_kind = kind;
    r.is_text    = 1'b1;
    r.text_out   = b;
    return r;
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] w);
    logic [2:0] r;
    case (w)
      KW_TRUE:  r = 3'd4;
      KW_FALSE: r = 3'd5;
      KW_NULL:  r = 3'd4;
      default:  r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] kw_letter(input logic [1:0] w, input logic [2:0] p);
    logic [7:0] r;
    r = 8'h00;
    case (w)
      KW_TRUE: begin
        case (p)
          3'd0: r = 8'h74;
          3'd1: r = 8'h72;
          3'd2: r = 8'h75;
          3'd3: r = 8'h65;
          default: r = 8'h00;
        endcase
      end
      KW_FALSE: begin
        case (p)
          3'd0: r = 8'h66;
          3'd1: r = 8'h61;
          3'd2: r = 8'h6C;
          3'd3: r = 8'h73;
          3'd4: r = 8'h65;
          default: r = 8'h00;
        endcase
      end
      KW_NULL: begin
        case (p)
          3'd0: r = 8'h6E;
          3'd1: r = 8'h75;
          3'd2: r = 8'h6C;
          3'd3: r = 8'h6C;
          default: r = 8'h00;
        endcase
      end
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b inside {[8'h09:8'h0D], 8'h20};
  endfunction

  // Handle a byte as the start of a new token
  function automatic idle_t idle_step(input logic [7:0] b, input logic eot);
    idle_t r;
    r    = '0;
    r.st = SCAN_IDLE;
    case (b)
      CH_LBRACE:   begin r.n = 2'd1; r.r0 = mk_tok(KIND_LBRACE);   end
      CH_RBRACE:   begin r.n = 2'd1; r.r0 = mk_tok(KIND_RBRACE);   end
      CH_LBRACKET: begin r.n = 2'd1; r.r0 = mk_tok(KIND_LBRACKET); end
      CH_RBRACKET: begin r.n = 2'd1; r.r0 = mk_tok(KIND_RBRACKET); end
      CH_COLON:    begin r.n = 2'd1; r.r0 = mk_tok(KIND_COLON);    end
      CH_COMMA:    begin r.n = 2'd1; r.r0 = mk_tok(KIND_COMMA);    end
      CH_T, CH_F, CH_N: begin
        if (eot) begin
          r.n  = 2'd1;
          r.r0 = mk_tok(KIND_ERROR);
        end else begin
          r.st.mode     = MODE_KEYWORD;
          r.st.kw_which = (b == CH_T) ? KW_TRUE : (b == CH_F) ? KW_FALSE : KW_NULL;
          r.st.kw_pos   = 3'd1;
        end
      end
      CH_QUOTE: begin
        if (eot) begin
          r.n  = 2'd1;
          r.r0 = mk_tok(KIND_ERROR);
        end else begin
          r.st.mode = MODE_STRING;
        end
      end
      CH_MINUS: begin
        r.n = 2'd1;
        if (eot) begin
          r.r0 = mk_tok(KIND_ERROR);
        end else begin
          r.r0      = mk_text(KIND_INT, b);
          r.st.mode = MODE_NUMBER;
        end
      end
      default: begin
        if (is_space(b)) begin
          r.n = 2'd0;
        end else if (is_digit(b)) begin
          r.r0 = mk_text(KIND_INT, b);
          if (eot) begin
            r.n  = 2'd2;
            r.r1 = mk_tok(KIND_INT);
          end else begin
            r.n             = 2'd1;
            r.st.mode       = MODE_NUMBER;
            r.st.seen_digit = 1'b1;
          end
        end else begin
          r.n  = 2'd1;
          r.r0 = mk_tok(KIND_ERROR);
        end
      end
    endcase
    return r;
  endfunction

endpackage

// ===== src/jbt_lexer.sv =====
// Scanner state and per-byte token logic of the JSON byte tokenizer.
// Depends on jbt_pkg for types, codes and the idle-byte helper.
module jbt_lexer
  import jbt_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  in_t   in_item,
  output push_t push
);

  scan_t      st_r;
  scan_t      st_nxt;
  idle_t      id;
  logic [7:0] b;
  logic       eot;
  logic [2:0] pos1;
  logic       kw_hit;
  logic       num_cont;
  logic [3:0] num_kind;
  push_t      res;

  assign b        = in_item.text_byte;
  assign eot      = in_item.end_of_text;
  assign pos1     = st_r.kw_pos + 3'd1;
  assign kw_hit   = (st_r.kw_pos < kw_len(st_r.kw_which)) &&
                    (b == kw_letter(st_r.kw_which, st_r.kw_pos));
  assign num_cont = is_digit(b) || ((b == CH_DOT) && !st_r.seen_dot);
  assign num_kind = !st_r.seen_digit ? KIND_ERROR :
                    st_r.seen_dot ? KIND_FLOAT : KIND_INT;

  // Work out results and next state for the registered byte
  always_comb begin
    res    = '0;
    st_nxt = st_r;
    id     = idle_step(b, eot);
    case (st_r.mode)
      MODE_STRING: begin
        if (b == CH_QUOTE) begin
          res.n  = 2'd1;
          res.r0 = mk_tok(KIND_STRING);
          st_nxt = SCAN_IDLE;
        end else begin
          res.r0 = mk_text(KIND_STRING, b);
          if (eot) begin
            res.n  = 2'd2;
            res.r1 = mk_tok(KIND_ERROR);
          end else begin
            res.n = 2'd1;
          end
        end
      end
      MODE_KEYWORD: begin
        if (kw_hit) begin
          if (pos1 == kw_len(st_r.kw_which)) begin
            res.n  = 2'd1;
            res.r0 = mk_tok(KIND_TRUE + {2'b00, st_r.kw_which});
            st_nxt = SCAN_IDLE;
          end else if (eot) begin
            res.n  = 2'd1;
            res.r0 = mk_tok(KIND_ERROR);
          end else begin
            st_nxt.kw_pos = pos1;
          end
        end else begin
          res.n  = 2'd1;
          res.r0 = mk_tok(KIND_ERROR);
          st_nxt = SCAN_IDLE;
        end
      end
      MODE_NUMBER: begin
        if (num_cont) begin
          if (b == CH_DOT) begin
            st_nxt.seen_dot = 1'b1;
          end else begin
            st_nxt.seen_digit = 1'b1;
          end
          res.r0 = mk_text(KIND_INT, b);
          if (eot) begin
            // Close with the kind that includes this byte
            res.n  = 2'd2;
            res.r1 = mk_tok(!st_nxt.seen_digit ? KIND_ERROR :
                            st_nxt.seen_dot ? KIND_FLOAT : KIND_INT);
          end else begin
            res.n = 2'd1;
          end
        end else begin
          // Close the number, then treat the byte as a token start
          res.r0 = mk_tok(num_kind);
          res.r1 = id.r0;
          res.n  = 2'd1 + id.n;
          st_nxt = id.st;
        end
      end
      default: begin
        res.n  = id.n;
        res.r0 = id.r0;
        res.r1 = id.r1;
        st_nxt = id.st;
      end
    endcase
    if (eot) begin
      st_nxt = SCAN_IDLE;
    end
    // Flag the final result of this byte
    if (res.n == 2'd1) begin
      res.r0.last_of_item = 1'b1;
    end
    if (res.n == 2'd2) begin
      res.r1.last_of_item = 1'b1;
    end
    if (!adv) begin
      res.n = 2'd0;
    end
  end

  assign push = res;

  // Advance scanner state once per consumed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= SCAN_IDLE;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

endmodule

// ===== src/jbt_out_queue.sv =====
// Four-entry result queue: takes up to two results a cycle, gives one.
// Depends on jbt_pkg for the result and push types.
module jbt_out_queue
  import jbt_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_data
);

  out_t       mem_r [4];
  logic [1:0] wr_ptr_r;
  logic [1:0] wr_ptr_nxt;
  logic [1:0] rd_ptr_r;
  logic [1:0] rd_ptr_nxt;
  logic [2:0] cnt_r;
  logic [2:0] cnt_nxt;
  logic       pop;

  // Room for a full two-result transaction
  assign room      = (cnt_r <= 3'd2);
  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  assign wr_ptr_nxt = wr_ptr_r + push.n;
  assign rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
  assign cnt_nxt    = cnt_r + {1'b0, push.n} - {2'b00, pop};

  // Store incoming results
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_ptr_r + 2'd1] <= push.r1;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      cnt_r    <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== src/json_byte_tokenizer_core.sv =====
// JSON byte tokenizer top level: input register, lexer and result queue.
// Depends on jbt_pkg, jbt_lexer and jbt_out_queue.
//
// Takes one byte of JSON text per cycle and gives tokens (punctuation, true,
// false, null, string, int, float, error) and the bytes of strings and
// numbers as text results; last_of_item marks the final result of each byte.
// A byte is registered, then scanned in the next cycle; once the queue has
// room, its zero, one or two results are written to a four-entry queue, so
// the first result of a byte passes the input register and the queue before
// it is offered. Input is taken at one byte per cycle as long as the result
// port drains at one result per cycle; the single-result output port is the
// limit, so a byte that causes two results (a number closed by another token,
// or a number or string ended by end_of_text) leaves its second in the queue.
module json_byte_tokenizer_core
  import jbt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  in_t   in_r;
  logic  in_vld_r;
  logic  in_vld_nxt;
  logic  room;
  logic  adv;
  push_t push;

  // Consume the registered byte when the queue can take its results
  assign adv        = in_vld_r && room;
  assign in_ready   = !in_vld_r || adv;
  assign in_vld_nxt = (in_valid && in_ready) ? 1'b1 : (adv ? 1'b0 : in_vld_r);

  // Hold the accepted transaction
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  jbt_lexer u_lexer (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_item (in_r),
    .push    (push)
  );

  jbt_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
